/* design/value_to_radix_digits_macros.svh */
// ----------------------------------------------------------------------------
// value_to_radix_digits_macros.svh
// Assertion macros shared by the radix digit converter.
// ----------------------------------------------------------------------------
`ifndef VALUE_TO_RADIX_DIGITS_MACROS_SVH
`define VALUE_TO_RADIX_DIGITS_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define VRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/vrd_pkg.sv */
// ----------------------------------------------------------------------------
// vrd_pkg
// Types, constants and helpers for the radix digit converter.
// ----------------------------------------------------------------------------
package vrd_pkg;

  localparam int unsigned BASE_WIDTH  = 6;
  localparam int unsigned DIGIT_WIDTH = 6;
  localparam int unsigned CHAR_WIDTH  = 7;
  localparam int unsigned STEP_WIDTH  = 3;

  localparam logic [BASE_WIDTH-1:0]  MIN_BASE   = 6'd2;
  localparam logic [BASE_WIDTH-1:0]  MAX_BASE   = 6'd36;
  localparam logic [DIGIT_WIDTH-1:0] DEC_DIGITS = 6'd10;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_A     = 7'd65;

  // Quotient bits resolved per digit (digit < 64)
  localparam logic [STEP_WIDTH-1:0] STEP_FIRST = 3'(DIGIT_WIDTH - 1);
  localparam logic [STEP_WIDTH-1:0] STEP_LAST  = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FETCH,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;      // start a run with a valid base
    logic load_bad;  // start a single error result
    logic search;    // one power search step
    logic fetch;     // clear digit, arm divide
    logic div;       // one restoring divide step
    logic pop;       // move to next lower power
  } cmd_t;

  typedef struct packed {
    logic base_bad;     // incoming base is out of range
    logic search_stop;  // next power would exceed value
    logic div_last;     // final divide step
    logic cnt_zero;     // current power is the unit
  } stat_t;

  function automatic logic [CHAR_WIDTH-1:0] char_of(input logic [DIGIT_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + CHAR_WIDTH'(d);
    end else begin
      c = CHAR_A + CHAR_WIDTH'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

/* design/vrd_if.sv */
// ----------------------------------------------------------------------------
// vrd_if
// Valid/ready channels of the radix digit converter.
// ----------------------------------------------------------------------------
interface vrd_in_if #(
  parameter int unsigned VALUE_WIDTH = 31
);
  logic                             valid;
  logic                             ready;
  logic [VALUE_WIDTH-1:0]           value;
  logic [vrd_pkg::BASE_WIDTH-1:0]   base;

  modport source (output valid, output value, output base, input ready);
  modport sink   (input valid, input value, input base, output ready);
endinterface

interface vrd_out_if;
  logic                             valid;
  logic                             ready;
  logic [vrd_pkg::DIGIT_WIDTH-1:0]  digit;
  logic [vrd_pkg::CHAR_WIDTH-1:0]   digit_char;
  logic                             last_digit;
  logic                             bad_base;

  modport source (output valid, output digit, output digit_char, output last_digit,
                  output bad_base, input ready);
  modport sink   (input valid, input digit, input digit_char, input last_digit,
                  input bad_base, output ready);
endinterface

/* design/vrd_datapath.sv */
// ----------------------------------------------------------------------------
// vrd_datapath
// Power search, power table and per-digit restoring divider.
// ----------------------------------------------------------------------------
`include "value_to_radix_digits_macros.svh"

module vrd_datapath #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vrd_pkg::cmd_t                     cmd_i,
  output vrd_pkg::stat_t                    stat_o,
  input  logic [VALUE_WIDTH-1:0]            value_i,
  input  logic [vrd_pkg::BASE_WIDTH-1:0]    base_i,
  output logic [vrd_pkg::DIGIT_WIDTH-1:0]   digit_o,
  output logic [vrd_pkg::CHAR_WIDTH-1:0]    digit_char_o,
  output logic                              last_digit_o,
  output logic                              bad_base_o
);

  localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH);
  localparam int unsigned PROD_W = VALUE_WIDTH + vrd_pkg::BASE_WIDTH;
  localparam int unsigned SH_W   = VALUE_WIDTH + vrd_pkg::DIGIT_WIDTH - 1;

  logic [VALUE_WIDTH-1:0]          rem_q, rem_d;
  logic [VALUE_WIDTH-1:0]          wt_q, wt_d;
  logic [vrd_pkg::BASE_WIDTH-1:0]  base_q, base_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [vrd_pkg::STEP_WIDTH-1:0]  step_q, step_d;
  logic [vrd_pkg::DIGIT_WIDTH-1:0] dig_q, dig_d;
  logic                            bad_q, bad_d;

  // powers of the base, index = exponent
  logic [VALUE_WIDTH-1:0] pow_mem [VALUE_WIDTH];
  logic [VALUE_WIDTH-1:0] pow_rd_q;

  logic [PROD_W-1:0] prod;
  logic [SH_W-1:0]   shifted;
  logic              ge;

  assign prod    = {{vrd_pkg::BASE_WIDTH{1'b0}}, wt_q} * {{VALUE_WIDTH{1'b0}}, base_q};
  assign shifted = {{(vrd_pkg::DIGIT_WIDTH-1){1'b0}}, pow_rd_q} << step_q;
  assign ge      = {{(vrd_pkg::DIGIT_WIDTH-1){1'b0}}, rem_q} >= shifted;

  assign stat_o.base_bad    = (base_i < vrd_pkg::MIN_BASE) || (base_i > vrd_pkg::MAX_BASE);
  assign stat_o.search_stop = prod > {{vrd_pkg::BASE_WIDTH{1'b0}}, rem_q};
  assign stat_o.div_last    = step_q == vrd_pkg::STEP_LAST;
  assign stat_o.cnt_zero    = cnt_q == '0;

  always_comb begin
    rem_d  = rem_q;
    wt_d   = wt_q;
    base_d = base_q;
    cnt_d  = cnt_q;
    step_d = step_q;
    dig_d  = dig_q;
    bad_d  = bad_q;
    if (cmd_i.load) begin
      rem_d  = value_i;
      base_d = base_i;
      wt_d   = VALUE_WIDTH'(1);
      cnt_d  = '0;
      bad_d  = 1'b0;
    end
    if (cmd_i.load_bad) begin
      cnt_d = '0;
      dig_d = '0;
      bad_d = 1'b1;
    end
    if (cmd_i.search && !stat_o.search_stop) begin
      wt_d  = prod[VALUE_WIDTH-1:0];
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (cmd_i.fetch) begin
      dig_d  = '0;
      step_d = vrd_pkg::STEP_FIRST;
    end
    if (cmd_i.div) begin
      if (ge) begin
        rem_d = rem_q - shifted[VALUE_WIDTH-1:0];
      end
      dig_d  = {dig_q[vrd_pkg::DIGIT_WIDTH-2:0], ge};
      step_d = step_q - vrd_pkg::STEP_WIDTH'(1);
    end
    if (cmd_i.pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      step_q <= '0;
      bad_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      step_q <= step_d;
      bad_q  <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    wt_q   <= wt_d;
    base_q <= base_d;
    dig_q  <= dig_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      pow_mem[cnt_q] <= wt_q;
    end
    pow_rd_q <= pow_mem[cnt_q];
  end

  assign digit_o      = dig_q;
  assign digit_char_o = vrd_pkg::char_of(dig_q);
  assign last_digit_o = stat_o.cnt_zero;
  assign bad_base_o   = bad_q;

  // power read lands on the first divide step, then must hold
  `VRD_ASSERT(a_div_pow_stable, (cmd_i.div && step_q != vrd_pkg::STEP_FIRST) |-> $stable(pow_rd_q), "power changed mid-divide")
  `VRD_ASSERT(a_pop_digit_range, cmd_i.pop |-> (!bad_q && dig_q < base_q), "digit out of range")
  `VRD_ASSERT(a_search_bounded, cmd_i.search |-> (wt_q <= rem_q || wt_q == VALUE_WIDTH'(1)), "power overran value")

endmodule

/* design/vrd_ctrl.sv */
// ----------------------------------------------------------------------------
// vrd_ctrl
// Sequencer: search, fetch power, divide, emit digit.
// ----------------------------------------------------------------------------
`include "value_to_radix_digits_macros.svh"

module vrd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  vrd_pkg::stat_t stat_i,
  output vrd_pkg::cmd_t  cmd_o
);

  vrd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vrd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      vrd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (stat_i.base_bad) begin
            cmd_o.load_bad = 1'b1;
            state_d        = vrd_pkg::ST_EMIT;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = vrd_pkg::ST_SEARCH;
          end
        end
      end
      vrd_pkg::ST_SEARCH: begin
        cmd_o.search = 1'b1;
        if (stat_i.search_stop) begin
          state_d = vrd_pkg::ST_FETCH;
        end
      end
      vrd_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = vrd_pkg::ST_DIV;
      end
      vrd_pkg::ST_DIV: begin
        cmd_o.div = 1'b1;
        if (stat_i.div_last) begin
          state_d = vrd_pkg::ST_EMIT;
        end
      end
      vrd_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.cnt_zero) begin
            state_d = vrd_pkg::ST_IDLE;
          end else begin
            cmd_o.pop = 1'b1;
            state_d   = vrd_pkg::ST_FETCH;
          end
        end
      end
      default: begin
        state_d = vrd_pkg::ST_IDLE;
      end
    endcase
  end

  `VRD_ASSERT(a_one_side, !(in_ready_o && out_valid_o), "accepting while a digit is pending")
  `VRD_ASSERT_NEXT(a_last_frees, out_valid_o && out_ready_i && stat_i.cnt_zero, in_ready_o, "not idle after last digit")
  `VRD_ASSERT(a_cmd_onehot, $onehot0(cmd_o), "more than one datapath command")

endmodule

/* design/value_to_radix_digits.sv */
// ----------------------------------------------------------------------------
// value_to_radix_digits
// Integer to base-N digit converter, most significant digit first.
// ----------------------------------------------------------------------------
// Each input item carries an unsigned value and a base. For a base from 2 to
// 36 the block emits one output item per digit, most significant first, the
// final one flagged by last_digit; digit_char spells the digit as '0'..'9'
// then 'A'..'Z'. A zero value gives the single digit 0. A base below 2 or
// above 36 gives one item with bad_base set, digit 0 and last_digit set.
// One item is converted at a time; in_i.ready is high only while idle.
// For a value of n digits the run first steps through the n powers of the
// base (one multiply-compare per power), writing each to the power table;
// then per digit it reads the power back from the power table, runs the
// restoring divide (six quotient bits, one per step) and emits one output
// item, held until the sink is ready. A rejected base goes straight to its
// single output item. No clearing pass after reset.
// ----------------------------------------------------------------------------
module value_to_radix_digits #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  vrd_in_if.sink   in_i,
  vrd_out_if.source out_o
);

  vrd_pkg::cmd_t  cmd;
  vrd_pkg::stat_t stat;

  // sequencer: owns both handshakes
  vrd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: power table, divider and the output item registers
  vrd_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .value_i      (in_i.value),
    .base_i       (in_i.base),
    .digit_o      (out_o.digit),
    .digit_char_o (out_o.digit_char),
    .last_digit_o (out_o.last_digit),
    .bad_base_o   (out_o.bad_base)
  );

endmodule
